// File: src/assert_macros.svh
// Assertion macros shared by the line walker RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled during reset
`define VLT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check, active during reset as well
`define VLT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VLT_ASSERT(name, clk, rst, prop, msg)
`define VLT_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// File: src/vlt_pkg.sv
// Package: widths, codes and control types of the voxel line walker
`default_nettype none
package vlt_pkg;

   localparam int COORD_BITS     = 13;
   localparam int FRAC_SHIFT     = 10;
   localparam int FRAC_SCALE     = 1 << FRAC_SHIFT;
   localparam int MAG_BITS       = COORD_BITS;
   localparam int WIDTH_BITS     = 13;
   localparam int DEPTH_BITS     = 9;
   localparam int LEN_BITS       = 12;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_INDEX_BITS = 2;
   localparam int NO_STEP_BITS   = 30;
   localparam logic [NO_STEP_BITS-1:0] NO_STEP_NUM = 30'h3fffffff;
   localparam int NUM_BITS  = (MAG_BITS + FRAC_SHIFT > NO_STEP_BITS) ?
                              (MAG_BITS + FRAC_SHIFT) : NO_STEP_BITS;
   localparam int DEN_BITS  = (MAG_BITS > WIDTH_BITS) ? MAG_BITS : WIDTH_BITS;
   localparam int INC_BITS  = NUM_BITS;
   localparam int ACC_BITS  = 48;
   localparam int BND_BITS  = (COORD_BITS > WIDTH_BITS) ? COORD_BITS : WIDTH_BITS;
   localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);
   localparam logic [LEN_BITS-1:0] COUNT_MAX = {LEN_BITS{1'b1}};

   localparam logic [WIDTH_BITS-1:0] MAP_WIDTH_RESET = 13'd512;
   localparam logic [DEPTH_BITS-1:0] MAP_DEPTH_RESET = 9'd64;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_NEXT  = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP_DEPTH   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EDITOR_MODE = 2'd2;

   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_AXIS,
      ST_DIV,
      ST_EMIT
   } vlt_state_type;

   typedef struct packed {
      logic     in_ready;
      logic     load;
      logic     set_major;
      logic     div_start;
      logic     div_write;
      logic     emit;
      axis_type axis;
   } vlt_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_kind;
      logic axis_is_major;
      logic div_done;
      logic out_free;
   } vlt_status_type;

endpackage
`default_nettype wire

// File: src/vlt_if.sv
// Channel interfaces: request words in, response words out
`default_nettype none
interface vlt_req_if
   import vlt_pkg::*;
   ;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] start_z;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic signed [COORD_BITS-1:0] end_z;
   logic [LEN_BITS-1:0]          max_length;

   modport source (output valid, kind, start_x, start_y, start_z, end_x, end_y, end_z,
                   max_length, input ready);
   modport sink (input valid, kind, start_x, start_y, start_z, end_x, end_y, end_z,
                 max_length, output ready);
endinterface

interface vlt_rsp_if
   import vlt_pkg::*;
   ;
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] cell_x;
   logic signed [COORD_BITS-1:0] cell_y;
   logic signed [COORD_BITS-1:0] cell_z;
   logic                         cell_valid;
   logic                         last;

   modport source (output valid, cell_x, cell_y, cell_z, cell_valid, last, input ready);
   modport sink (input valid, cell_x, cell_y, cell_z, cell_valid, last, output ready);
endinterface
`default_nettype wire

// File: src/vlt_divider.sv
// Restoring divider, one quotient bit per cycle
`default_nettype none
`include "assert_macros.svh"
module vlt_divider
   import vlt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_BITS-1:0] numerator,
   input  wire logic [DEN_BITS-1:0] denominator,
   output logic                     done,
   output logic [NUM_BITS-1:0]      quotient
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NUM_BITS-1:0]     num_ff, num_in;
   logic [DEN_BITS-1:0]     den_ff, den_in;
   logic [DEN_BITS:0]       rem_ff, rem_in;
   logic [DEN_BITS:0]       shifted;
   logic                    fits;

   always_comb begin
      shifted = {rem_ff[DEN_BITS-1:0], num_ff[NUM_BITS-1]};
      fits    = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_BITS'(NUM_BITS);
         num_in  = numerator;
         den_in  = denominator;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? (shifted - {1'b0, den_ff}) : shifted;
         num_in = {num_ff[NUM_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

   `VLT_ASSERT(a_div_start_idle, clock, reset, start |-> !busy_ff, "divider restarted while busy")
   `VLT_ASSERT(a_div_done_after_busy, clock, reset, done_ff |-> $past(busy_ff), "done without a division")
   `VLT_ASSERT(a_div_den_nonzero, clock, reset, start |-> denominator != '0, "divide by zero")

endmodule
`default_nettype wire

// File: src/vlt_datapath.sv
// Datapath: endpoints, increments, accumulators, step logic and response register
`default_nettype none
`include "assert_macros.svh"
module vlt_datapath
   import vlt_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   vlt_req_if.sink                        req,
   vlt_rsp_if.source                      rsp,
   input  wire logic                      csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire vlt_cmd_type               cmd,
   output vlt_status_type                 status
);

   logic [WIDTH_BITS-1:0] width_ff;
   logic [DEPTH_BITS-1:0] depth_ff;
   logic                  editor_ff;

   logic [COORD_BITS-1:0] cur_ff [3];
   logic [COORD_BITS-1:0] end_ff [3];
   logic                  dir_ff [3];
   logic [MAG_BITS-1:0]   mag_ff [3];
   logic [INC_BITS-1:0]   inc_ff [3];
   logic [ACC_BITS-1:0]   acc_ff [3];
   logic [LEN_BITS-1:0]   count_ff;
   logic [LEN_BITS-1:0]   limit_ff;
   logic                  active_ff;

   logic                  out_valid_ff;
   logic [COORD_BITS-1:0] out_cell_ff [3];
   logic                  out_cell_valid_ff;
   logic                  out_last_ff;

   logic [COORD_BITS-1:0] start_c [3];
   logic [COORD_BITS-1:0] end_c [3];
   logic [COORD_BITS:0]   diff [3];
   logic [ACC_BITS:0]     sum [3];
   logic [ACC_BITS-1:0]   acc_sat [3];

   axis_type              major;
   logic                  load_start;
   logic [NUM_BITS-1:0]   div_num;
   logic [DEN_BITS-1:0]   div_den;
   logic [WIDTH_BITS-1:0] width_div;
   logic                  div_done;
   logic [NUM_BITS-1:0]   div_quo;
   logic [INC_BITS-1:0]   inc_val;
   logic [INC_BITS-1:0]   inc_half;
   logic [ACC_BITS-1:0]   acc_init;

   logic [LEN_BITS-1:0]   count_new;
   logic                  at_limit;
   logic                  at_end;
   axis_type              sel;
   logic [COORD_BITS-1:0] step;
   logic [BND_BITS-1:0]   bound;
   logic                  off_map;
   logic                  stop_map;
   logic                  last;
   logic                  out_free;

   assign start_c[0] = req.start_x;
   assign start_c[1] = req.start_y;
   assign start_c[2] = req.start_z;
   assign end_c[0]   = req.end_x;
   assign end_c[1]   = req.end_y;
   assign end_c[2]   = req.end_z;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      assign diff[a]    = {end_c[a][COORD_BITS-1], end_c[a]}
                        - {start_c[a][COORD_BITS-1], start_c[a]};
      assign sum[a]     = {1'b0, acc_ff[a]} + (ACC_BITS+1)'(inc_ff[a]);
      assign acc_sat[a] = sum[a][ACC_BITS] ? {ACC_BITS{1'b1}} : sum[a][ACC_BITS-1:0];
   end

   assign load_start = cmd.load && (req.kind == KIND_START);

   // major axis: x on ties with y or z, then y over z
   always_comb begin
      if (mag_ff[0] >= mag_ff[1] && mag_ff[0] >= mag_ff[2]) begin
         major = AXIS_X;
      end else if (mag_ff[1] >= mag_ff[2]) begin
         major = AXIS_Y;
      end else begin
         major = AXIS_Z;
      end
   end

   assign width_div = (width_ff == '0) ? WIDTH_BITS'(1) : width_ff;

   always_comb begin
      if (mag_ff[cmd.axis] == '0) begin
         div_num = NUM_BITS'(NO_STEP_NUM);
         div_den = DEN_BITS'(width_div);
      end else begin
         div_num = NUM_BITS'({mag_ff[major], {FRAC_SHIFT{1'b0}}});
         div_den = DEN_BITS'(mag_ff[cmd.axis]);
      end
   end

   vlt_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .done        (div_done),
      .quotient    (div_quo)
   );

   assign inc_val  = cmd.set_major ? INC_BITS'(FRAC_SCALE) : div_quo;
   assign inc_half = inc_val >> 1;
   assign acc_init = dir_ff[cmd.axis] ? ACC_BITS'(inc_half) : ACC_BITS'(inc_val - inc_half);

   // step: smallest accumulator, z first on ties, then y over x
   always_comb begin
      count_new = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      at_limit  = (limit_ff != '0) && (count_new == limit_ff);
      at_end    = (cur_ff[0] == end_ff[0]) && (cur_ff[1] == end_ff[1])
               && (cur_ff[2] == end_ff[2]);
      if (acc_ff[2] <= acc_ff[0] && acc_ff[2] <= acc_ff[1]) begin
         sel = AXIS_Z;
      end else if (acc_ff[0] < acc_ff[1]) begin
         sel = AXIS_X;
      end else begin
         sel = AXIS_Y;
      end
      step     = dir_ff[sel] ? cur_ff[sel] - 1'b1 : cur_ff[sel] + 1'b1;
      bound    = (sel == AXIS_Z) ? BND_BITS'(depth_ff) : BND_BITS'(width_ff);
      off_map  = step[COORD_BITS-1] || (BND_BITS'(step) >= bound);
      stop_map = !editor_ff && off_map;
      last     = at_limit || at_end || stop_map;
   end

   assign out_free = !out_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= MAP_WIDTH_RESET;
         depth_ff  <= MAP_DEPTH_RESET;
         editor_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MAP_WIDTH:   width_ff  <= csr_wdata[WIDTH_BITS-1:0];
            CSR_MAP_DEPTH:   depth_ff  <= csr_wdata[DEPTH_BITS-1:0];
            CSR_EDITOR_MODE: editor_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         limit_ff     <= '0;
         for (int a = 0; a < 3; a++) begin
            cur_ff[a] <= '0;
            end_ff[a] <= '0;
            dir_ff[a] <= 1'b0;
            mag_ff[a] <= '0;
            inc_ff[a] <= '0;
            acc_ff[a] <= '0;
         end
      end else begin
         if (load_start) begin
            for (int a = 0; a < 3; a++) begin
               cur_ff[a] <= start_c[a];
               end_ff[a] <= end_c[a];
               dir_ff[a] <= diff[a][COORD_BITS];
               mag_ff[a] <= diff[a][COORD_BITS] ? MAG_BITS'(-diff[a]) : MAG_BITS'(diff[a]);
            end
            count_ff  <= '0;
            limit_ff  <= req.max_length;
            active_ff <= 1'b1;
         end
         if (cmd.set_major || cmd.div_write) begin
            inc_ff[cmd.axis] <= inc_val;
            acc_ff[cmd.axis] <= acc_init;
         end
         if (cmd.emit && active_ff) begin
            count_ff <= count_new;
            if (!at_limit && !at_end) begin
               cur_ff[sel] <= step;
               if (!stop_map) begin
                  acc_ff[sel] <= acc_sat[sel];
               end
            end
            if (last) begin
               active_ff <= 1'b0;
            end
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         for (int a = 0; a < 3; a++) begin
            out_cell_ff[a] <= active_ff ? cur_ff[a] : '0;
         end
         out_cell_valid_ff <= active_ff;
         out_last_ff       <= active_ff && last;
      end
   end

   assign req.ready      = cmd.in_ready;
   assign rsp.valid      = out_valid_ff;
   assign rsp.cell_x     = out_cell_ff[0];
   assign rsp.cell_y     = out_cell_ff[1];
   assign rsp.cell_z     = out_cell_ff[2];
   assign rsp.cell_valid = out_cell_valid_ff;
   assign rsp.last       = out_last_ff;

   assign status.req_valid     = req.valid;
   assign status.req_kind      = req.kind;
   assign status.axis_is_major = (cmd.axis == major);
   assign status.div_done      = div_done;
   assign status.out_free      = out_free;

   `VLT_ASSERT(a_dp_emit_slot_free, clock, reset, cmd.emit |-> out_free, "emit into a full slot")
   `VLT_ASSERT(a_dp_no_last_on_empty, clock, reset, out_valid_ff && !out_cell_valid_ff |-> !out_last_ff, "last on an empty word")

endmodule
`default_nettype wire

// File: src/vlt_ctrl.sv
// Controller: accept, per-axis increment setup, emit sequencing
`default_nettype none
`include "assert_macros.svh"
module vlt_ctrl
   import vlt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire vlt_status_type status,
   output vlt_cmd_type         cmd
);

   vlt_state_type state_ff, state_in;
   axis_type      axis_ff, axis_in;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            axis_in = AXIS_X;
            if (status.req_valid) begin
               state_in = (status.req_kind == KIND_START) ? ST_AXIS : ST_EMIT;
            end
         end
         ST_AXIS: begin
            if (!status.axis_is_major) begin
               state_in = ST_DIV;
            end else if (axis_ff == AXIS_Z) begin
               state_in = ST_EMIT;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               if (axis_ff == AXIS_Z) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_AXIS;
                  axis_in  = axis_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.axis      = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.in_ready = 1'b1;
            cmd.load     = status.req_valid;
         end
         ST_AXIS: begin
            cmd.set_major = status.axis_is_major;
            cmd.div_start = !status.axis_is_major;
         end
         ST_DIV: begin
            cmd.div_write = status.div_done;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= AXIS_X;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   `VLT_ASSERT(a_ctrl_done_in_div, clock, reset, status.div_done |-> state_ff == ST_DIV, "divider done outside wait")
   `VLT_ASSERT(a_ctrl_axis_range, clock, reset, axis_ff != 2'd3, "axis counter out of range")
   `VLT_ASSERT(a_ctrl_emit_exit, clock, reset, state_ff == ST_EMIT |=> state_ff == ST_EMIT || state_ff == ST_IDLE, "bad exit from emit")

endmodule
`default_nettype wire

// File: src/voxel_line_traversal_top.sv
// Top level of the 3D voxel line walker
//
//   channel   direction  handshake        carries
//   req_port  in         valid/ready      kind, start and end cells, max_length
//   rsp_port  out        valid/ready      cell_x/y/z, cell_valid, last
//   csr_*     in         write enable     map_width, map_depth, editor_mode
//
// A next word goes straight to the emit state after acceptance; a start word first sets
// the minor-axis increments by two passes of the shared restoring divider.
// One word is in flight at a time; req_port.ready is high while the controller idles.
// The response register holds a word under stall, and the next request is
// taken while it waits.
// Reset is synchronous; no line is active after it.
`default_nettype none
module voxel_line_traversal_top
   import vlt_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   vlt_req_if.sink                        req_port,
   vlt_rsp_if.source                      rsp_port,
   input  wire logic                      csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   vlt_cmd_type    cmd;
   vlt_status_type status;

   vlt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   vlt_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req          (req_port),
      .rsp          (rsp_port),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status)
   );

endmodule
`default_nettype wire

// File: dv/voxel_line_traversal_top_test.sv
// Self-checking testbench for the voxel line walker: random and directed lines, scoreboarded
module voxel_line_traversal_top_test
   import vlt_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] ACC_CEILING = (64'd1 << ACC_BITS) - 1;
   localparam int          HOLD_CYCLES = 400;

   typedef struct {
      logic                         kind;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] start_z;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
      logic signed [COORD_BITS-1:0] end_z;
      logic [LEN_BITS-1:0]          max_length;
   } line_word_type;

   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic                         cell_valid;
      logic                         last;
   } walk_cell_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   vlt_req_if req_chan();
   vlt_rsp_if rsp_chan();

   voxel_line_traversal_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_port     (req_chan),
      .rsp_port     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [WIDTH_BITS-1:0]        map_width_q = MAP_WIDTH_RESET;
   logic [DEPTH_BITS-1:0]        map_depth_q = MAP_DEPTH_RESET;
   logic                         editor_q    = 1'b0;
   logic signed [COORD_BITS-1:0] walk_pos [3] = '{default: '0};
   logic signed [COORD_BITS-1:0] walk_end [3] = '{default: '0};
   logic                         walk_down [3] = '{default: 1'b0};
   logic [ACC_BITS-1:0]          walk_acc [3] = '{default: '0};
   logic [31:0]                  walk_inc [3] = '{default: '0};
   logic [LEN_BITS-1:0]          walk_count = '0;
   logic [LEN_BITS-1:0]          walk_limit = '0;
   logic                         walk_active = 1'b0;

   line_word_type line_words [$];
   walk_cell_type cells_due [$];
   line_word_type offered;
   int            words_queued = 0;
   int            words_sent   = 0;
   int            mismatches   = 0;
   int            send_gap     = 0;
   int            take_gap     = 0;
   int            hold_left    = 0;
   int            next_hold_at = 300;
   logic          send_calm    = 1'b0;
   logic          take_calm    = 1'b0;

   function automatic walk_cell_type take_cell();
      walk_cell_type                c;
      int                           ax;
      int                           nv_i;
      int                           bound_i;
      logic signed [COORD_BITS-1:0] nv;
      logic [63:0]                  sum;
      logic                         done;
      c.x          = walk_pos[0];
      c.y          = walk_pos[1];
      c.z          = walk_pos[2];
      c.cell_valid = 1'b1;
      done         = 1'b0;
      if (walk_count != COUNT_MAX) walk_count = walk_count + 1'b1;
      if (walk_limit != 0 && walk_count == walk_limit) begin
         done = 1'b1;
      end else if (walk_pos[0] == walk_end[0] && walk_pos[1] == walk_end[1] &&
                   walk_pos[2] == walk_end[2]) begin
         done = 1'b1;
      end else begin
         if (walk_acc[AXIS_Z] <= walk_acc[AXIS_X] && walk_acc[AXIS_Z] <= walk_acc[AXIS_Y])
            ax = AXIS_Z;
         else if (walk_acc[AXIS_X] < walk_acc[AXIS_Y])
            ax = AXIS_X;
         else
            ax = AXIS_Y;
         nv = walk_down[ax] ? walk_pos[ax] - 1'b1 : walk_pos[ax] + 1'b1;
         walk_pos[ax] = nv;
         nv_i = int'(nv);
         if (ax == AXIS_Z) bound_i = int'(map_depth_q);
         else bound_i = int'(map_width_q);
         if (!editor_q && (nv_i < 0 || nv_i >= bound_i)) begin
            done = 1'b1;
         end else begin
            sum = 64'(walk_acc[ax]) + 64'(walk_inc[ax]);
            walk_acc[ax] = ACC_BITS'((sum > ACC_CEILING) ? ACC_CEILING : sum);
         end
      end
      if (done) walk_active = 1'b0;
      c.last = done;
      return c;
   endfunction

   function automatic walk_cell_type walk_step(line_word_type w);
      walk_cell_type       none;
      longint              mag [3];
      longint unsigned     inc;
      longint unsigned     half;
      longint unsigned     div;
      int                  lead;
      int                  a;
      none = '{default: '0};
      if (w.kind == KIND_START) begin
         walk_pos[0] = w.start_x;
         walk_pos[1] = w.start_y;
         walk_pos[2] = w.start_z;
         walk_end[0] = w.end_x;
         walk_end[1] = w.end_y;
         walk_end[2] = w.end_z;
         for (a = 0; a < 3; a++) begin
            mag[a] = longint'(walk_end[a]) - longint'(walk_pos[a]);
            walk_down[a] = mag[a] < 0;
            if (mag[a] < 0) mag[a] = -mag[a];
         end
         if (mag[0] >= mag[1] && mag[0] >= mag[2]) lead = 0;
         else if (mag[1] >= mag[2]) lead = 1;
         else lead = 2;
         div = (map_width_q == 0) ? 64'd1 : 64'(map_width_q);
         for (a = 0; a < 3; a++) begin
            if (a == lead) inc = 64'(FRAC_SCALE);
            else if (mag[a] == 0) inc = 64'(NO_STEP_NUM) / div;
            else inc = 64'((mag[lead] * FRAC_SCALE) / mag[a]);
            if (inc > 64'hffff_ffff) inc = 64'hffff_ffff;
            walk_inc[a] = 32'(inc);
            half = inc / 2;
            walk_acc[a] = ACC_BITS'(walk_down[a] ? half : inc - half);
         end
         walk_limit  = w.max_length;
         walk_count  = '0;
         walk_active = 1'b1;
         return take_cell();
      end
      if (!walk_active) return none;
      return take_cell();
   endfunction

   function automatic int pick_gap(logic calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 99) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int any_coord();
      logic [COORD_BITS-1:0] v;
      v = COORD_BITS'($urandom);
      return int'($signed(v));
   endfunction

   function automatic int clip_coord(int v);
      if (v < -4096) return -4096;
      if (v > 4095) return 4095;
      return v;
   endfunction

   task automatic queue_word(line_word_type w);
      line_words.insert(line_words.size(), w);
      words_queued++;
   endtask

   task automatic queue_next();
      line_word_type w;
      w.kind       = KIND_NEXT;
      w.start_x    = COORD_BITS'($urandom);
      w.start_y    = COORD_BITS'($urandom);
      w.start_z    = COORD_BITS'($urandom);
      w.end_x      = COORD_BITS'($urandom);
      w.end_y      = COORD_BITS'($urandom);
      w.end_z      = COORD_BITS'($urandom);
      w.max_length = LEN_BITS'($urandom);
      queue_word(w);
   endtask

   task automatic queue_start(int sx, int sy, int sz, int ex, int ey, int ez, int limit);
      line_word_type w;
      w.kind       = KIND_START;
      w.start_x    = COORD_BITS'(sx);
      w.start_y    = COORD_BITS'(sy);
      w.start_z    = COORD_BITS'(sz);
      w.end_x      = COORD_BITS'(ex);
      w.end_y      = COORD_BITS'(ey);
      w.end_z      = COORD_BITS'(ez);
      w.max_length = LEN_BITS'(limit);
      queue_word(w);
   endtask

   task automatic queue_random_line();
      int lim_xy, lim_z, reach, pick, cells, nexts, limit;
      int sx, sy, sz, ex, ey, ez;
      lim_xy = int'(map_width_q);
      if (lim_xy == 0) lim_xy = 16;
      if (lim_xy > 4096) lim_xy = 4096;
      lim_z = int'(map_depth_q);
      if (lim_z == 0) lim_z = 16;
      if ($urandom_range(0, 19) == 0) queue_next();
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         sx = any_coord();
         sy = any_coord();
         sz = any_coord();
         ex = any_coord();
         ey = any_coord();
         ez = any_coord();
      end else begin
         reach = (pick < 80) ? 6 : 24;
         sx = $urandom_range(0, lim_xy - 1);
         sy = $urandom_range(0, lim_xy - 1);
         sz = $urandom_range(0, lim_z - 1);
         ex = clip_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
         ey = clip_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
         ez = clip_coord(sz + int'($urandom_range(0, 2 * reach)) - reach);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) limit = 0;
      else if (pick < 80) limit = $urandom_range(1, 16);
      else limit = $urandom_range(0, 4095);
      queue_start(sx, sy, sz, ex, ey, ez, limit);
      cells = ((ex > sx) ? ex - sx : sx - ex) + ((ey > sy) ? ey - sy : sy - ey) +
              ((ez > sz) ? ez - sz : sz - ez);
      if (cells > 40) cells = 40;
      nexts = cells + $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) nexts = $urandom_range(0, nexts);
      repeat (nexts) queue_next();
   endtask

   task automatic fill_random(int count);
      int goal;
      goal = words_queued + count;
      while (words_queued < goal) queue_random_line();
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (words_sent != words_queued || cells_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // call just after a rising edge with the block idle
   task automatic set_map(input logic [WIDTH_BITS-1:0] width,
                          input logic [DEPTH_BITS-1:0] depth, input logic editor);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_MAP_WIDTH;
      csr_wdata    <= width;
      @(posedge clock);
      csr_index    <= CSR_MAP_DEPTH;
      csr_wdata    <= CSR_DATA_BITS'(depth);
      @(posedge clock);
      csr_index    <= CSR_EDITOR_MODE;
      csr_wdata    <= CSR_DATA_BITS'(editor);
      @(posedge clock);
      csr_write_en <= 1'b0;
      map_width_q = width;
      map_depth_q = depth;
      editor_q    = editor;
   endtask

   task automatic log_mismatch(string what, walk_cell_type want, walk_cell_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $write("%0t %s: expected (%0d,%0d,%0d) valid %0b last %0b", $time, what,
                want.x, want.y, want.z, want.cell_valid, want.last);
         $display(", got (%0d,%0d,%0d) valid %0b last %0b",
                  got.x, got.y, got.z, got.cell_valid, got.last);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid      <= 1'b0;
         req_chan.kind       <= KIND_START;
         req_chan.start_x    <= '0;
         req_chan.start_y    <= '0;
         req_chan.start_z    <= '0;
         req_chan.end_x      <= '0;
         req_chan.end_y      <= '0;
         req_chan.end_z      <= '0;
         req_chan.max_length <= '0;
         send_gap            <= 0;
      end else begin
         if ($urandom_range(0, 99) == 0) send_calm <= !send_calm;
         if (req_chan.valid && req_chan.ready) begin
            cells_due.insert(cells_due.size(), walk_step(offered));
            words_sent <= words_sent + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap != 0) begin
               send_gap       <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (line_words.size() != 0) begin
               offered = line_words[0];
               line_words.delete(0);
               req_chan.kind       <= offered.kind;
               req_chan.start_x    <= offered.start_x;
               req_chan.start_y    <= offered.start_y;
               req_chan.start_z    <= offered.start_z;
               req_chan.end_x      <= offered.end_x;
               req_chan.end_y      <= offered.end_y;
               req_chan.end_z      <= offered.end_z;
               req_chan.max_length <= offered.max_length;
               req_chan.valid      <= 1'b1;
               send_gap            <= pick_gap(send_calm);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response ready, with long hold-offs so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         take_gap       <= 0;
         hold_left      <= 0;
      end else begin
         if ($urandom_range(0, 99) == 0) take_calm <= !take_calm;
         if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (words_sent >= next_hold_at) begin
            hold_left      <= HOLD_CYCLES;
            next_hold_at   <= next_hold_at + 1100;
            rsp_chan.ready <= 1'b0;
         end else if (take_gap != 0) begin
            take_gap       <= take_gap - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            take_gap       <= pick_gap(take_calm);
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      walk_cell_type got;
      walk_cell_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.x          = rsp_chan.cell_x;
         got.y          = rsp_chan.cell_y;
         got.z          = rsp_chan.cell_z;
         got.cell_valid = rsp_chan.cell_valid;
         got.last       = rsp_chan.last;
         if (cells_due.size() == 0) begin
            want = '{default: '0};
            log_mismatch("word with none outstanding", want, got);
         end else begin
            want = cells_due[0];
            cells_due.delete(0);
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.cell_valid !== want.cell_valid || got.last !== want.last)
               log_mismatch("cell mismatch", want, got);
         end
      end
   end

   initial begin
      #(20_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_index           = CSR_MAP_WIDTH;
      csr_wdata           = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_map(MAP_WIDTH_RESET, MAP_DEPTH_RESET, 1'b0);

      queue_next();
      queue_start(0, 0, 0, 0, 0, 0, 0);
      queue_next();
      queue_start(1, 2, 3, 4, 4, 3, 0);
      repeat (5) queue_next();
      queue_start(10, 10, 10, 3, 20, 5, 1);
      queue_next();
      queue_start(0, 5, 5, -5, 5, 5, 0);
      queue_next();
      queue_start(511, 5, 63, 515, 5, 63, 0);
      queue_next();
      queue_start(-4096, 4095, -4096, 4095, -4096, 4095, 4095);
      queue_next();
      queue_start(5, 5, 40, 5, 5, 30, 0);
      repeat (3) queue_next();
      queue_start(20, 30, 2, 22, 31, 2, 3);
      repeat (3) queue_next();
      wait_idle();

      set_map(13'd4096, 9'd256, 1'b0);
      fill_random(550);
      wait_idle();

      set_map(13'd1, 9'd1, 1'b0);
      fill_random(150);
      wait_idle();

      // hold y on the top edge so the idle axis wraps round
      set_map(13'd8191, 9'd511, 1'b1);
      queue_start(-4096, 4095, 0, 4095, 4095, 0, 0);
      repeat (80) queue_next();
      fill_random(400);
      wait_idle();

      set_map(13'd0, 9'd0, 1'b0);
      fill_random(100);
      wait_idle();

      set_map(13'd0, 9'd0, 1'b1);
      fill_random(100);
      wait_idle();

      repeat (3) begin
         set_map(WIDTH_BITS'($urandom_range(1, 4096)), DEPTH_BITS'($urandom_range(1, 256)),
                 1'($urandom_range(0, 1)));
         fill_random(170);
         wait_idle();
      end

      repeat (100) @(posedge clock);
      if (mismatches == 0 && cells_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/vlt_pkg.sv
src/vlt_if.sv
src/vlt_divider.sv
src/vlt_datapath.sv
src/vlt_ctrl.sv
src/voxel_line_traversal_top.sv
dv/voxel_line_traversal_top_test.sv
